// File: rtl/kwm_pkg.sv
// Shared types and fixed field widths for the k-way merge core.
package kwm_pkg;

    // Fixed field widths of the record and result transactions
    localparam int RUN_IDX_W   = 3;
    localparam int RUN_CNT_W   = 4;
    localparam int KEY_PORT_W  = 64;

    // Reset value of the run count register
    localparam logic [RUN_CNT_W-1:0] RUN_COUNT_RESET = 4'd8;

    // Largest run count that the register can express
    localparam int RUN_CNT_MAX = (1 << RUN_CNT_W) - 1;

    // Merge sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_EMIT
    } kwm_state_t;

endpackage

// File: rtl/kwm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module kwm_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/k_way_merge_sorted_runs_core.sv
// K-way merge of ascending record runs, ordered by end key, with heads kept in RAM.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+---------------------------------------------
//  s_       | in        | s_valid / s_ready   | run_index, start_key, end_key, last_in_run
//  m_       | out       | m_valid / m_ready   | out_start_key, out_end_key, source_run,
//           |           |                     | refill_wanted, merge_done
//  cfg_     | in        | cfg_wr_en           | cfg_wr_data (run count)
//
// Every pick of a drain scans all n head entries (n = effective run count) through the
// single read port of the head RAM. Reset (synchronous, aresetn low) clears all head
// valid bits and merge flags; the head RAM itself needs no clearing. A stalled m_ready
// holds the result register and stops the next pick from emitting; s_ready stays low
// while a drain is under way.
module k_way_merge_sorted_runs_core
    import kwm_pkg::*;
#(
    parameter int MAX_RUNS  = 8,
    parameter int KEY_WIDTH = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic [RUN_CNT_W-1:0]  cfg_wr_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [RUN_IDX_W-1:0]  s_run_index,
    input  logic [KEY_PORT_W-1:0] s_start_key,
    input  logic [KEY_PORT_W-1:0] s_end_key,
    input  logic                  s_last_in_run,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [KEY_PORT_W-1:0] m_out_start_key,
    output logic [KEY_PORT_W-1:0] m_out_end_key,
    output logic [RUN_IDX_W-1:0]  m_source_run,
    output logic                  m_refill_wanted,
    output logic                  m_merge_done
);

    localparam int AW      = $clog2(MAX_RUNS);
    localparam int CAP     = (MAX_RUNS < RUN_CNT_MAX) ? MAX_RUNS : RUN_CNT_MAX;
    localparam int ENTRY_W = 2 * KEY_WIDTH;

    // Configuration and merge control state
    logic [RUN_CNT_W-1:0] run_count_reg;
    kwm_state_t           state_reg, state_next;
    logic [MAX_RUNS-1:0]  head_valid_reg, head_valid_next;
    logic [MAX_RUNS-1:0]  head_more_reg, head_more_next;
    logic [RUN_CNT_W-1:0] primed_count_reg, primed_count_next;
    logic [RUN_IDX_W-1:0] awaited_run_reg, awaited_run_next;
    logic                 pending_reg, pending_next;
    logic                 finished_reg, finished_next;

    // Scan state
    logic [RUN_CNT_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic                 rd_vld_reg, rd_vld_next;
    logic [AW-1:0]        rd_idx_reg, rd_idx_next;
    logic                 found_reg, found_next;
    logic [AW-1:0]        best_idx_reg, best_idx_next;
    logic [KEY_WIDTH-1:0] best_start_reg, best_start_next;
    logic [KEY_WIDTH-1:0] best_end_reg, best_end_next;

    // Result register
    logic                  m_valid_reg, m_valid_next;
    logic [KEY_PORT_W-1:0] m_start_reg, m_end_reg;
    logic [RUN_IDX_W-1:0]  m_run_reg;
    logic                  m_refill_reg, m_done_reg;

    // Head RAM ports
    logic               ram_wr_en;
    logic [AW-1:0]      ram_wr_addr;
    logic [ENTRY_W-1:0] ram_wr_data;
    logic [AW-1:0]      ram_rd_addr;
    logic [ENTRY_W-1:0] ram_rd_data;

    // Derived control
    logic [RUN_CNT_W-1:0] eff_n;
    logic                 s_take;
    logic [AW-1:0]        s_addr;
    logic                 s_in_range;
    logic                 out_free;
    logic                 out_load;
    logic                 load_head;
    logic                 start_scan;
    logic [AW-1:0]        scan_addr;
    logic                 scan_last;
    logic                 best_more;
    logic                 any_left;
    logic [KEY_WIDTH-1:0] rd_start;
    logic [KEY_WIDTH-1:0] rd_end;

    // Clamp the run count register into 1..CAP, the smaller of MAX_RUNS and RUN_CNT_MAX
    always_comb begin
        if (run_count_reg == '0) begin
            eff_n = RUN_CNT_W'(1);
        end else if (int'(run_count_reg) > CAP) begin
            eff_n = RUN_CNT_W'(CAP);
        end else begin
            eff_n = run_count_reg;
        end
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_take     = s_valid && s_ready;
    assign s_addr     = AW'(s_run_index);
    assign s_in_range = ({1'b0, s_run_index} < eff_n);
    assign out_free   = !m_valid_reg || m_ready;
    assign scan_addr  = AW'(scan_cnt_reg);
    assign scan_last  = (scan_cnt_reg == eff_n - RUN_CNT_W'(1));
    assign best_more  = head_more_reg[best_idx_reg];
    assign any_left   = |(head_valid_reg & ~(MAX_RUNS'(1) << best_idx_reg));
    assign rd_start   = ram_rd_data[ENTRY_W-1:KEY_WIDTH];
    assign rd_end     = ram_rd_data[KEY_WIDTH-1:0];

    // Decide whether an accepted record loads a head and whether it starts a drain
    always_comb begin
        load_head  = 1'b0;
        start_scan = 1'b0;
        if (s_take && !finished_reg && s_in_range) begin
            if (primed_count_reg < eff_n) begin
                load_head  = 1'b1;
                start_scan = (primed_count_next == eff_n);
            end else if (pending_reg && (s_run_index == awaited_run_reg)) begin
                load_head  = 1'b1;
                start_scan = 1'b1;
            end
        end
    end

    assign out_load = (state_reg == ST_EMIT) && out_free && !cfg_wr_en && found_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start_scan) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST: begin
                if (found_next) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (!found_reg) begin
                    state_next = ST_IDLE;
                end else if (out_load) begin
                    if (best_more || !any_left) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_wr_en) begin
            state_next = ST_IDLE;
        end
    end

    // Datapath and flag updates
    always_comb begin
        head_valid_next   = head_valid_reg;
        head_more_next    = head_more_reg;
        primed_count_next = primed_count_reg;
        awaited_run_next  = awaited_run_reg;
        pending_next      = pending_reg;
        finished_next     = finished_reg;
        scan_cnt_next     = scan_cnt_reg;
        rd_pend_next      = 1'b0;
        rd_vld_next       = 1'b0;
        rd_idx_next       = rd_idx_reg;
        found_next        = found_reg;
        best_idx_next     = best_idx_reg;
        best_start_next   = best_start_reg;
        best_end_next     = best_end_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        ram_wr_en         = 1'b0;
        ram_wr_addr       = s_addr;
        ram_wr_data       = {s_start_key[KEY_WIDTH-1:0], s_end_key[KEY_WIDTH-1:0]};
        ram_rd_addr       = scan_addr;

        // Count a newly primed run
        if (s_take && !finished_reg && s_in_range && (primed_count_reg < eff_n)
            && !head_valid_reg[s_addr]) begin
            primed_count_next = primed_count_reg + RUN_CNT_W'(1);
        end

        // Store the record as the run's head
        if (load_head) begin
            ram_wr_en               = 1'b1;
            head_valid_next[s_addr] = 1'b1;
            head_more_next[s_addr]  = !s_last_in_run;
            pending_next            = 1'b0;
        end

        // Reset scan bookkeeping when a pick begins
        if (start_scan || (out_load && !best_more && any_left)) begin
            scan_cnt_next = '0;
            found_next    = 1'b0;
        end

        // Issue one head read per cycle
        if (state_reg == ST_SCAN) begin
            rd_pend_next  = 1'b1;
            rd_vld_next   = head_valid_reg[scan_addr];
            rd_idx_next   = scan_addr;
            scan_cnt_next = scan_cnt_reg + RUN_CNT_W'(1);
        end

        // Keep the smallest valid head; ties stay with the lower run
        if (rd_pend_reg && rd_vld_reg && (!found_reg || (rd_end < best_end_reg))) begin
            found_next      = 1'b1;
            best_idx_next   = rd_idx_reg;
            best_start_next = rd_start;
            best_end_next   = rd_end;
        end

        // No head left at the end of a scan ends the merge
        if ((state_reg == ST_LAST) && !found_next) begin
            finished_next = 1'b1;
        end

        // Emit the pick and retire its head
        if (out_load) begin
            m_valid_next                  = 1'b1;
            head_valid_next[best_idx_reg] = 1'b0;
            if (best_more) begin
                pending_next     = 1'b1;
                awaited_run_next = RUN_IDX_W'(best_idx_reg);
            end else if (!any_left) begin
                finished_next = 1'b1;
            end
        end

        // A register write restarts the merge
        if (cfg_wr_en) begin
            head_valid_next   = '0;
            head_more_next    = '0;
            primed_count_next = '0;
            awaited_run_next  = '0;
            pending_next      = 1'b0;
            finished_next     = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_count_reg    <= RUN_COUNT_RESET;
            state_reg        <= ST_IDLE;
            head_valid_reg   <= '0;
            head_more_reg    <= '0;
            primed_count_reg <= '0;
            awaited_run_reg  <= '0;
            pending_reg      <= 1'b0;
            finished_reg     <= 1'b0;
            rd_pend_reg      <= 1'b0;
            found_reg        <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                run_count_reg <= cfg_wr_data;
            end
            state_reg        <= state_next;
            head_valid_reg   <= head_valid_next;
            head_more_reg    <= head_more_next;
            primed_count_reg <= primed_count_next;
            awaited_run_reg  <= awaited_run_next;
            pending_reg      <= pending_next;
            finished_reg     <= finished_next;
            rd_pend_reg      <= rd_pend_next;
            found_reg        <= found_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        scan_cnt_reg   <= scan_cnt_next;
        rd_vld_reg     <= rd_vld_next;
        rd_idx_reg     <= rd_idx_next;
        best_idx_reg   <= best_idx_next;
        best_start_reg <= best_start_next;
        best_end_reg   <= best_end_next;
        if (out_load) begin
            m_start_reg  <= KEY_PORT_W'(best_start_reg);
            m_end_reg    <= KEY_PORT_W'(best_end_reg);
            m_run_reg    <= RUN_IDX_W'(best_idx_reg);
            m_refill_reg <= best_more;
            m_done_reg   <= !best_more && !any_left;
        end
    end

    // Head record store
    kwm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_RUNS)
    ) u_head_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign m_valid         = m_valid_reg;
    assign m_out_start_key = m_start_reg;
    assign m_out_end_key   = m_end_reg;
    assign m_source_run    = m_run_reg;
    assign m_refill_wanted = m_refill_reg;
    assign m_merge_done    = m_done_reg;

`ifndef NO_ASSERTIONS
    // A merge is never both waiting for a refill and finished
    a_pend_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pending_reg && finished_reg))
        else $error("refill pending after merge finished");

    // The awaited run has no live head
    a_await_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg |-> !head_valid_reg[AW'(awaited_run_reg)])
        else $error("awaited run still holds a head");

    // While a drain runs, nothing waits and the merge is open
    a_busy_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (!pending_reg && !finished_reg))
        else $error("drain running with pending or finished set");

    // Emitting the final record closes the merge
    a_done_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && !best_more && !any_left) |=> finished_reg)
        else $error("final record emitted without finishing");
`endif

endmodule
